// ----- src/elmc_pkg.sv -----
// ----------------------------------------------------------------------------
// elmc_pkg
// Shared types and constants of the exclusion lattice Monte Carlo update block.
// ----------------------------------------------------------------------------
package elmc_pkg;

  // Fixed port widths
  localparam int OPCODE_W     = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int SITE_COUNT_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SITES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_PROB  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_PROB   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACH_PROB = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DETACH_PROB = 3'd4;

  // Request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_UPDATE = 3'd0,
    OP_ACCUM  = 3'd1,
    OP_READ   = 3'd2,
    OP_LOAD   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPD_RJ,
    ST_UPD_RI,
    ST_UPD_RI1,
    ST_UPD_CAP,
    ST_UPD_WJ,
    ST_UPD_WI,
    ST_UPD_WI1,
    ST_ACC,
    ST_CLR,
    ST_RD_OUT,
    ST_RD_CAP
  } ctrl_state_e;

  // Inputs to the site update rules
  typedef struct packed {
    logic bit_j;      // lattice at j before the request
    logic bit_i;      // lattice at i before the request
    logic bit_i1;     // lattice at i+1 before the request
    logic att_hit;    // u_bulk below attach probability
    logic det_hit;    // u_bulk below detach probability
    logic ent_hit;    // u_edge below entry probability
    logic ext_hit;    // u_edge below exit probability
    logic i_is_zero;
    logic i_is_last;
    logic i_eq_j;
    logic i1_eq_j;
  } rule_in_t;

  // Values written back by an update
  typedef struct packed {
    logic new_j;
    logic new_i;
    logic new_i1;
    logic wr_i1;      // i+1 takes part in a hop
  } rule_out_t;

endpackage

// ----- src/elmc_ram.sv -----
// ----------------------------------------------------------------------------
// elmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module elmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/elmc_rules.sv -----
// ----------------------------------------------------------------------------
// elmc_rules
// Site update rules: bulk attach/detach at j, then injection, exit or hop at i.
// ----------------------------------------------------------------------------
module elmc_rules (
  input  elmc_pkg::rule_in_t  rin_i,
  output elmc_pkg::rule_out_t rout_o
);

  logic new_j;
  logic eff_i;
  logic eff_i1;

  // Bulk kinetics at j
  assign new_j = rin_i.bit_j ? ~rin_i.det_hit : rin_i.att_hit;

  // Lattice at i and i+1 as seen after the bulk step
  assign eff_i  = rin_i.i_eq_j  ? new_j : rin_i.bit_i;
  assign eff_i1 = rin_i.i1_eq_j ? new_j : rin_i.bit_i1;

  // Transport step: injection first, then exit, else a forward hop
  always_comb begin
    rout_o.new_j  = new_j;
    rout_o.new_i  = eff_i;
    rout_o.new_i1 = eff_i1;
    rout_o.wr_i1  = 1'b0;
    if (rin_i.i_is_zero && !eff_i && rin_i.ent_hit) begin
      rout_o.new_i = 1'b1;
    end else if (rin_i.i_is_last) begin
      rout_o.new_i = eff_i & ~rin_i.ext_hit;
    end else if (eff_i && !eff_i1) begin
      rout_o.new_i  = 1'b0;
      rout_o.new_i1 = 1'b1;
      rout_o.wr_i1  = 1'b1;
    end
  end

endmodule

// ----- src/elmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// elmc_ctrl
// Request sequencer: read-modify-write of the lattice and counter memories,
// counter sweeps and the clearing pass after reset.
// ----------------------------------------------------------------------------
module elmc_ctrl #(
  parameter int MAX_SITES   = 1024,
  parameter int COUNT_WIDTH = 32,
  parameter int PROB_BITS   = 16,
  localparam int AW         = $clog2(MAX_SITES),
  localparam int NS_W       = AW + 1,
  localparam int PW         = PROB_BITS + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request
  input  logic                               start,
  output logic                               busy,
  input  logic [elmc_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [AW-1:0]                      hop_site_i,
  input  logic [AW-1:0]                      bulk_site_i,
  input  logic [PROB_BITS-1:0]               u_bulk_i,
  input  logic [PROB_BITS-1:0]               u_edge_i,
  input  logic                               load_bit_i,
  // Configuration
  input  logic [NS_W-1:0]                    sites_i,
  input  logic [PW-1:0]                      entry_prob_i,
  input  logic [PW-1:0]                      exit_prob_i,
  input  logic [PW-1:0]                      attach_prob_i,
  input  logic [PW-1:0]                      detach_prob_i,
  // Result
  output logic                               done_o,
  output logic                               occupied_o,
  output logic [elmc_pkg::SITE_COUNT_W-1:0]  site_count_o,
  output logic                               status_o,
  // Lattice memory
  output logic                               lat_we_o,
  output logic [AW-1:0]                      lat_waddr_o,
  output logic                               lat_wdata_o,
  output logic [AW-1:0]                      lat_raddr_o,
  input  logic                               lat_rdata_i,
  // Counter memory
  output logic                               cnt_we_o,
  output logic [AW-1:0]                      cnt_waddr_o,
  output logic [COUNT_WIDTH-1:0]             cnt_wdata_o,
  output logic [AW-1:0]                      cnt_raddr_o,
  input  logic [COUNT_WIDTH-1:0]             cnt_rdata_i
);

  elmc_pkg::ctrl_state_e state_q, state_d;

  // Request registers
  elmc_pkg::op_e        op_q;
  logic [AW-1:0]        i_q;
  logic [AW-1:0]        j_q;
  logic [PROB_BITS-1:0] ub_q;
  logic [PROB_BITS-1:0] ue_q;
  logic                 iok_q;

  // Sweep counter and pending counter write
  logic [NS_W-1:0] k_q;
  logic            pend_q;
  logic [AW-1:0]   paddr_q;

  // Captured lattice bits for an update
  logic bj_q, bi_q, bi1_q;

  // Result registers
  logic                              done_q;
  logic                              occ_q;
  logic [elmc_pkg::SITE_COUNT_W-1:0] cnt_q;
  logic                              status_q;

  // Combinational controls
  logic                              accept;
  logic                              in_i_ok;
  logic                              in_j_ok;
  logic                              k_below_n;
  logic                              k_at_end;
  logic                              res_set;
  logic                              res_occ;
  logic [elmc_pkg::SITE_COUNT_W-1:0] res_cnt;
  logic                              res_status;
  logic [COUNT_WIDTH-1:0]            cnt_sat;

  elmc_pkg::rule_in_t  rin;
  elmc_pkg::rule_out_t rout;

  assign busy      = (state_q != elmc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign in_i_ok   = {1'b0, hop_site_i} < sites_i;
  assign in_j_ok   = {1'b0, bulk_site_i} < sites_i;
  assign k_below_n = k_q < sites_i;
  assign k_at_end  = (k_q == NS_W'(MAX_SITES - 1));

  // Saturating increment for the accumulate sweep
  assign cnt_sat = (&cnt_rdata_i) ? cnt_rdata_i
                                  : cnt_rdata_i + COUNT_WIDTH'(lat_rdata_i);

  // Update rule inputs
  assign rin.bit_j     = bj_q;
  assign rin.bit_i     = bi_q;
  assign rin.bit_i1    = bi1_q;
  assign rin.att_hit   = {1'b0, ub_q} < attach_prob_i;
  assign rin.det_hit   = {1'b0, ub_q} < detach_prob_i;
  assign rin.ent_hit   = {1'b0, ue_q} < entry_prob_i;
  assign rin.ext_hit   = {1'b0, ue_q} < exit_prob_i;
  assign rin.i_is_zero = (i_q == '0);
  assign rin.i_is_last = ({1'b0, i_q} == sites_i - NS_W'(1));
  assign rin.i_eq_j    = (i_q == j_q);
  assign rin.i1_eq_j   = (({1'b0, i_q} + NS_W'(1)) == {1'b0, j_q});

  elmc_rules u_rules (
    .rin_i  (rin),
    .rout_o (rout)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      elmc_pkg::ST_INIT: begin
        if (k_at_end) state_d = elmc_pkg::ST_IDLE;
      end
      elmc_pkg::ST_IDLE: begin
        if (accept) begin
          case (elmc_pkg::op_e'(opcode_i))
            elmc_pkg::OP_UPDATE: begin
              if (in_i_ok && in_j_ok) state_d = elmc_pkg::ST_UPD_RJ;
              else if (in_i_ok) state_d = elmc_pkg::ST_RD_OUT;
            end
            elmc_pkg::OP_ACCUM: state_d = elmc_pkg::ST_ACC;
            elmc_pkg::OP_READ: begin
              if (in_i_ok) state_d = elmc_pkg::ST_RD_OUT;
            end
            elmc_pkg::OP_CLEAR: state_d = elmc_pkg::ST_CLR;
            default: state_d = elmc_pkg::ST_IDLE;
          endcase
        end
      end
      elmc_pkg::ST_UPD_RJ:  state_d = elmc_pkg::ST_UPD_RI;
      elmc_pkg::ST_UPD_RI:  state_d = elmc_pkg::ST_UPD_RI1;
      elmc_pkg::ST_UPD_RI1: state_d = elmc_pkg::ST_UPD_CAP;
      elmc_pkg::ST_UPD_CAP: state_d = elmc_pkg::ST_UPD_WJ;
      elmc_pkg::ST_UPD_WJ:  state_d = elmc_pkg::ST_UPD_WI;
      elmc_pkg::ST_UPD_WI:  state_d = elmc_pkg::ST_UPD_WI1;
      elmc_pkg::ST_UPD_WI1: state_d = elmc_pkg::ST_IDLE;
      elmc_pkg::ST_ACC: begin
        if (!k_below_n) state_d = elmc_pkg::ST_RD_OUT;
      end
      elmc_pkg::ST_CLR: begin
        if (k_at_end) state_d = elmc_pkg::ST_RD_OUT;
      end
      elmc_pkg::ST_RD_OUT: state_d = elmc_pkg::ST_RD_CAP;
      elmc_pkg::ST_RD_CAP: state_d = elmc_pkg::ST_IDLE;
      default: state_d = elmc_pkg::ST_INIT;
    endcase
  end

  // Memory controls and result
  always_comb begin
    lat_we_o    = 1'b0;
    lat_waddr_o = i_q;
    lat_wdata_o = 1'b0;
    lat_raddr_o = i_q;
    cnt_we_o    = 1'b0;
    cnt_waddr_o = k_q[AW-1:0];
    cnt_wdata_o = '0;
    cnt_raddr_o = i_q;
    res_set     = 1'b0;
    res_occ     = 1'b0;
    res_cnt     = '0;
    res_status  = 1'b0;
    case (state_q)
      elmc_pkg::ST_INIT: begin
        lat_we_o    = 1'b1;
        lat_waddr_o = k_q[AW-1:0];
        cnt_we_o    = 1'b1;
      end
      elmc_pkg::ST_IDLE: begin
        if (accept) begin
          case (elmc_pkg::op_e'(opcode_i))
            elmc_pkg::OP_UPDATE: begin
              // a bad bulk site alone still reports the hop site
              if (!in_i_ok) begin
                res_set    = 1'b1;
                res_status = 1'b1;
              end
            end
            elmc_pkg::OP_READ: begin
              if (!in_i_ok) begin
                res_set    = 1'b1;
                res_status = 1'b1;
              end
            end
            elmc_pkg::OP_LOAD: begin
              res_set = 1'b1;
              if (in_i_ok) begin
                lat_we_o    = 1'b1;
                lat_waddr_o = hop_site_i;
                lat_wdata_o = load_bit_i;
                res_occ     = load_bit_i;
              end else begin
                res_status = 1'b1;
              end
            end
            elmc_pkg::OP_ACCUM, elmc_pkg::OP_CLEAR: ;
            default: begin
              res_set    = 1'b1;
              res_status = 1'b1;
            end
          endcase
        end
      end
      elmc_pkg::ST_UPD_RJ:  lat_raddr_o = j_q;
      elmc_pkg::ST_UPD_RI:  lat_raddr_o = i_q;
      elmc_pkg::ST_UPD_RI1: lat_raddr_o = i_q + AW'(1);
      elmc_pkg::ST_UPD_CAP: ;
      elmc_pkg::ST_UPD_WJ: begin
        lat_we_o    = 1'b1;
        lat_waddr_o = j_q;
        lat_wdata_o = rout.new_j;
      end
      elmc_pkg::ST_UPD_WI: begin
        lat_we_o    = 1'b1;
        lat_waddr_o = i_q;
        lat_wdata_o = rout.new_i;
      end
      elmc_pkg::ST_UPD_WI1: begin
        lat_we_o    = rout.wr_i1;
        lat_waddr_o = i_q + AW'(1);
        lat_wdata_o = rout.new_i1;
        res_set     = 1'b1;
        res_occ     = rout.new_i;
      end
      elmc_pkg::ST_ACC: begin
        // Read site k while the counter of site k-1 is written back
        lat_raddr_o = k_q[AW-1:0];
        cnt_raddr_o = k_q[AW-1:0];
        cnt_we_o    = pend_q;
        cnt_waddr_o = paddr_q;
        cnt_wdata_o = cnt_sat;
      end
      elmc_pkg::ST_CLR: cnt_we_o = 1'b1;
      elmc_pkg::ST_RD_OUT: ;
      elmc_pkg::ST_RD_CAP: begin
        res_set = 1'b1;
        res_occ = iok_q & lat_rdata_i;
        // an update only gets here when its bulk site is out of range
        res_status = (op_q == elmc_pkg::OP_UPDATE);
        if (op_q == elmc_pkg::OP_READ) begin
          res_cnt = elmc_pkg::SITE_COUNT_W'(cnt_rdata_i);
        end
      end
      default: ;
    endcase
  end

  // State and sweep registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= elmc_pkg::ST_INIT;
      k_q     <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= res_set;
      case (state_q)
        elmc_pkg::ST_INIT, elmc_pkg::ST_CLR: begin
          k_q <= k_at_end ? '0 : k_q + NS_W'(1);
        end
        elmc_pkg::ST_IDLE: begin
          k_q    <= '0;
          pend_q <= 1'b0;
        end
        elmc_pkg::ST_ACC: begin
          pend_q <= k_below_n;
          if (k_below_n) k_q <= k_q + NS_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= elmc_pkg::op_e'(opcode_i);
      i_q   <= hop_site_i;
      j_q   <= bulk_site_i;
      ub_q  <= u_bulk_i;
      ue_q  <= u_edge_i;
      iok_q <= in_i_ok;
    end
    if (state_q == elmc_pkg::ST_ACC) paddr_q <= k_q[AW-1:0];
    if (state_q == elmc_pkg::ST_UPD_RI)  bj_q  <= lat_rdata_i;
    if (state_q == elmc_pkg::ST_UPD_RI1) bi_q  <= lat_rdata_i;
    if (state_q == elmc_pkg::ST_UPD_CAP) bi1_q <= lat_rdata_i;
    if (res_set) begin
      occ_q    <= res_occ;
      cnt_q    <= res_cnt;
      status_q <= res_status;
    end
  end

  assign done_o       = done_q;
  assign occupied_o   = occ_q;
  assign site_count_o = cnt_q;
  assign status_o     = status_q;

endmodule

// ----- src/exclusion_lattice_mc_update.sv -----
// ----------------------------------------------------------------------------
// exclusion_lattice_mc_update
// Monte Carlo update engine for an exclusion lattice with attach/detach.
// ----------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; each request gives
// exactly one result, shown for one cycle with done_o high, in the cycle after
// the request's work ends, and the receiver cannot hold it off. Load requests
// and rejected requests (bad site or unused opcode) finish at once: the result
// comes the next cycle and busy stays low. The one exception is an update with
// a valid hop site but a bad bulk site, which reads the hop site like a read.
// A read is busy for an output and a capture step; an update reads j, i, i+1
// from the single-read-port lattice memory, captures, then writes j and i back
// and i+1 only on a hop; an accumulate sweeps the active sites, one site per
// cycle through both memories; a counter clear sweeps all MAX_SITES counters.
// After reset the block runs a clearing pass over all MAX_SITES sites of both
// memories with busy high; configuration writes are taken during it.
// Configuration may only be written while busy is low and no result is pending.
module exclusion_lattice_mc_update #(
  parameter int MAX_SITES   = 1024,
  parameter int COUNT_WIDTH = 32,
  parameter int PROB_BITS   = 16,
  localparam int AW         = $clog2(MAX_SITES),
  localparam int NS_W       = AW + 1,
  localparam int PW         = PROB_BITS + 1,
  localparam int CFG_DW     = (NS_W > PW) ? NS_W : PW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [elmc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DW-1:0]                  cfg_data_i,
  // Request
  input  logic                               start,
  output logic                               busy,
  input  logic [elmc_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [AW-1:0]                      hop_site_i,
  input  logic [AW-1:0]                      bulk_site_i,
  input  logic [PROB_BITS-1:0]               u_bulk_i,
  input  logic [PROB_BITS-1:0]               u_edge_i,
  input  logic                               load_bit_i,
  // Result
  output logic                               done_o,
  output logic                               occupied_o,
  output logic [elmc_pkg::SITE_COUNT_W-1:0]  site_count_o,
  output logic                               status_o
);

  logic [NS_W-1:0] num_sites_q;
  logic [PW-1:0]   entry_prob_q;
  logic [PW-1:0]   exit_prob_q;
  logic [PW-1:0]   attach_prob_q;
  logic [PW-1:0]   detach_prob_q;
  logic [NS_W-1:0] sites;

  logic                   lat_we;
  logic [AW-1:0]          lat_waddr;
  logic                   lat_wdata;
  logic [AW-1:0]          lat_raddr;
  logic                   lat_rdata;
  logic                   cnt_we;
  logic [AW-1:0]          cnt_waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [AW-1:0]          cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sites_q   <= NS_W'(MAX_SITES);
      entry_prob_q  <= '0;
      exit_prob_q   <= '0;
      attach_prob_q <= '0;
      detach_prob_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        elmc_pkg::CFG_NUM_SITES:   num_sites_q   <= cfg_data_i[NS_W-1:0];
        elmc_pkg::CFG_ENTRY_PROB:  entry_prob_q  <= cfg_data_i[PW-1:0];
        elmc_pkg::CFG_EXIT_PROB:   exit_prob_q   <= cfg_data_i[PW-1:0];
        elmc_pkg::CFG_ATTACH_PROB: attach_prob_q <= cfg_data_i[PW-1:0];
        elmc_pkg::CFG_DETACH_PROB: detach_prob_q <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // Sites in use, capped at the lattice size
  assign sites = (num_sites_q > NS_W'(MAX_SITES)) ? NS_W'(MAX_SITES) : num_sites_q;

  elmc_ctrl #(
    .MAX_SITES   (MAX_SITES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .PROB_BITS   (PROB_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .hop_site_i    (hop_site_i),
    .bulk_site_i   (bulk_site_i),
    .u_bulk_i      (u_bulk_i),
    .u_edge_i      (u_edge_i),
    .load_bit_i    (load_bit_i),
    .sites_i       (sites),
    .entry_prob_i  (entry_prob_q),
    .exit_prob_i   (exit_prob_q),
    .attach_prob_i (attach_prob_q),
    .detach_prob_i (detach_prob_q),
    .done_o        (done_o),
    .occupied_o    (occupied_o),
    .site_count_o  (site_count_o),
    .status_o      (status_o),
    .lat_we_o      (lat_we),
    .lat_waddr_o   (lat_waddr),
    .lat_wdata_o   (lat_wdata),
    .lat_raddr_o   (lat_raddr),
    .lat_rdata_i   (lat_rdata),
    .cnt_we_o      (cnt_we),
    .cnt_waddr_o   (cnt_waddr),
    .cnt_wdata_o   (cnt_wdata),
    .cnt_raddr_o   (cnt_raddr),
    .cnt_rdata_i   (cnt_rdata)
  );

  // Occupancy lattice
  elmc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SITES)
  ) u_lattice_ram (
    .clk_i   (clk_i),
    .we_i    (lat_we),
    .waddr_i (lat_waddr),
    .wdata_i (lat_wdata),
    .raddr_i (lat_raddr),
    .rdata_o (lat_rdata)
  );

  // Per-site occupancy counters
  elmc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_SITES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for exclusion_lattice_mc_update. A predictor keeps its
// own lattice and occupancy counters and works out each result as a request
// is accepted. A monitor compares every done_o strobe with the oldest
// prediction. Directed tests cover reset values, boundary injection and exit,
// bulk attach and detach, rejected sites and opcodes, and the single-site,
// zero-site and oversized-site settings. Random traffic follows over several
// configurations, with random request gaps.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SITES      = 1024;
  localparam int AW             = 10;
  localparam int PROB_BITS      = 16;
  localparam int CFG_DW         = 17;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 75;
  localparam int NUM_PHASES     = 8;
  localparam int OPCODE_W       = elmc_pkg::OPCODE_W;
  localparam int CFG_IDX_W      = elmc_pkg::CFG_IDX_W;
  localparam int SITE_COUNT_W   = elmc_pkg::SITE_COUNT_W;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_DW-1:0]   PROB_ONE        = 17'd65536;

  typedef struct {
    logic [OPCODE_W-1:0]  opcode;
    logic [AW-1:0]        hop;
    logic [AW-1:0]        bulk;
    logic [PROB_BITS-1:0] u_bulk;
    logic [PROB_BITS-1:0] u_edge;
    logic                 load_bit;
  } site_req_t;

  typedef struct {
    logic [OPCODE_W-1:0]     opcode;
    logic                    occupied;
    logic [SITE_COUNT_W-1:0] count;
    logic                    status;
  } site_reply_t;

  // DUT connections
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i    = '0;
  logic [CFG_DW-1:0]       cfg_data_i   = '0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic [OPCODE_W-1:0]     opcode_i     = '0;
  logic [AW-1:0]           hop_site_i   = '0;
  logic [AW-1:0]           bulk_site_i  = '0;
  logic [PROB_BITS-1:0]    u_bulk_i     = '0;
  logic [PROB_BITS-1:0]    u_edge_i     = '0;
  logic                    load_bit_i   = 1'b0;
  logic                    done_o;
  logic                    occupied_o;
  logic [SITE_COUNT_W-1:0] site_count_o;
  logic                    status_o;

  // Predictor state: lattice, counters and register copies
  bit                      lat_bits [MAX_SITES];
  logic [SITE_COUNT_W-1:0] occ_cnt  [MAX_SITES];
  logic [10:0]             cfg_num_sites = 11'd1024;
  logic [CFG_DW-1:0]       cfg_entry     = '0;
  logic [CFG_DW-1:0]       cfg_exit      = '0;
  logic [CFG_DW-1:0]       cfg_attach    = '0;
  logic [CFG_DW-1:0]       cfg_detach    = '0;

  site_reply_t site_reply_q[$];
  site_reply_t got_want;

  bit idle_en = 1'b1;
  int n_errors  = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_update  = 0;
  int n_accum   = 0;
  int n_reject  = 0;
  int idle_cycles = 0;

  exclusion_lattice_mc_update u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .hop_site_i   (hop_site_i),
    .bulk_site_i  (bulk_site_i),
    .u_bulk_i     (u_bulk_i),
    .u_edge_i     (u_edge_i),
    .load_bit_i   (load_bit_i),
    .done_o       (done_o),
    .occupied_o   (occupied_o),
    .site_count_o (site_count_o),
    .status_o     (status_o)
  );

  always #1 clk_i = ~clk_i;

  // Sites in use; oversized counts clamp to the lattice size
  function automatic int unsigned active_sites();
    return (cfg_num_sites > MAX_SITES) ? MAX_SITES : cfg_num_sites;
  endfunction

  // Apply one request to the predicted lattice, return its result
  function automatic site_reply_t lattice_step(input site_req_t r);
    site_reply_t y;
    int unsigned n;
    int unsigned i;
    int unsigned j;
    int unsigned last;
    bit i_ok;
    n = active_sites();
    i = r.hop;
    j = r.bulk;
    i_ok = (i < n);
    y.opcode = r.opcode;
    y.occupied = 1'b0;
    y.count = '0;
    y.status = 1'b0;
    case (r.opcode)
      elmc_pkg::OP_UPDATE: begin
        if (i_ok && j < n) begin
          last = n - 1;
          // bulk attach / detach at j
          if (!lat_bits[j]) begin
            if (r.u_bulk < cfg_attach) lat_bits[j] = 1'b1;
          end else if (r.u_bulk < cfg_detach) begin
            lat_bits[j] = 1'b0;
          end
          // injection, exit, or forward hop, on the updated lattice
          if (i == 0 && !lat_bits[0] && r.u_edge < cfg_entry) begin
            lat_bits[0] = 1'b1;
          end else if (i == last) begin
            if (lat_bits[last] && r.u_edge < cfg_exit) lat_bits[last] = 1'b0;
          end else if (lat_bits[i] && !lat_bits[i+1]) begin
            lat_bits[i] = 1'b0;
            lat_bits[i+1] = 1'b1;
          end
        end else begin
          y.status = 1'b1;
        end
      end
      elmc_pkg::OP_ACCUM: begin
        for (int k = 0; k < n; k++) begin
          if (lat_bits[k] && occ_cnt[k] != '1) occ_cnt[k] = occ_cnt[k] + 1'b1;
        end
      end
      elmc_pkg::OP_READ: begin
        if (i_ok) y.count = occ_cnt[i];
        else y.status = 1'b1;
      end
      elmc_pkg::OP_LOAD: begin
        if (i_ok) lat_bits[i] = r.load_bit;
        else y.status = 1'b1;
      end
      elmc_pkg::OP_CLEAR: begin
        for (int k = 0; k < MAX_SITES; k++) occ_cnt[k] = '0;
      end
      default: begin
        y.status = 1'b1;
        i_ok = 1'b0;
      end
    endcase
    y.occupied = i_ok ? lat_bits[i] : 1'b0;
    return y;
  endfunction

  function automatic site_req_t mk_req(input logic [OPCODE_W-1:0] op,
                                       input int unsigned hop, bulk, ub, ue,
                                       input bit lb);
    site_req_t r;
    r.opcode = op;
    r.hop = hop[AW-1:0];
    r.bulk = bulk[AW-1:0];
    r.u_bulk = ub[PROB_BITS-1:0];
    r.u_edge = ue[PROB_BITS-1:0];
    r.load_bit = lb;
    return r;
  endfunction

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Present one request and hold it until accepted; optional gap afterwards
  task automatic send_site_req(input site_req_t r);
    opcode_i    <= r.opcode;
    hop_site_i  <= r.hop;
    bulk_site_i <= r.bulk;
    u_bulk_i    <= r.u_bulk;
    u_edge_i    <= r.u_edge;
    load_bit_i  <= r.load_bit;
    start       <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    site_reply_q.push_back(lattice_step(r));
    n_sent++;
    if (r.opcode == elmc_pkg::OP_UPDATE) n_update++;
    if (r.opcode == elmc_pkg::OP_ACCUM) n_accum++;
    if (site_reply_q[$].status) n_reject++;
    if (idle_en && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Stop requesting until every result is back and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (site_reply_q.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_config(input logic [10:0] n, input logic [CFG_DW-1:0] p_in,
                            p_out, p_att, p_det);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DW-1:0]    val [5];
    idx = '{elmc_pkg::CFG_NUM_SITES, elmc_pkg::CFG_ENTRY_PROB, elmc_pkg::CFG_EXIT_PROB,
            elmc_pkg::CFG_ATTACH_PROB, elmc_pkg::CFG_DETACH_PROB};
    val = '{CFG_DW'(n), p_in, p_out, p_att, p_det};
    cfg_num_sites = n;
    cfg_entry     = p_in;
    cfg_exit      = p_out;
    cfg_attach    = p_att;
    cfg_detach    = p_det;
    for (int k = 0; k < 5; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Reset values: full lattice size, all probabilities zero
  task automatic test_reset_defaults();
    send_site_req(mk_req(elmc_pkg::OP_READ, 1023, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_LOAD, 1023, 0, 0, 0, 1));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 1023, 0, 0, 0, 0));
    wait_idle();
  endtask

  // Injection at site 0, hops down a short lattice, exit at the last site,
  // counter accumulate/read/clear and rejected requests
  task automatic test_boundary_edges();
    set_config(11'd4, PROB_ONE, PROB_ONE, '0, '0);
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 3, 65535, 65535, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 3, 65535, 65535, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 1, 3, 0, 65535, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 2, 0, 0, 65535, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 3, 0, 0, 65535, 0));
    send_site_req(mk_req(elmc_pkg::OP_LOAD, 3, 0, 0, 0, 1));
    send_site_req(mk_req(elmc_pkg::OP_ACCUM, 0, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_READ, 3, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 4, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 1023, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_READ, 1023, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_LOAD, 1023, 0, 0, 0, 1));
    for (int k = OP_UNUSED_FIRST; k < 2**OPCODE_W; k++)
      send_site_req(mk_req(k[OPCODE_W-1:0], 3, 1023, 65535, 65535, 1));
    send_site_req(mk_req(elmc_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_READ, 3, 0, 0, 0, 0));
    wait_idle();
  endtask

  // Attach and detach at j, including i equal to j; draw equal to the
  // probability gives no event
  task automatic test_bulk_kinetics();
    set_config(11'd8, '0, '0, PROB_ONE, PROB_ONE);
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 5, 5, 65535, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 6, 6, 0, 0, 0));
    wait_idle();
    set_config(11'd8, '0, '0, '0, '0);
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 1, 2, 0, 0, 0));
    wait_idle();
  endtask

  // One-site lattice: injection tried first, then exit, same draw
  task automatic test_single_site();
    set_config(11'd1, 17'd32768, 17'd32768, '0, '0);
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 0, 0, 32767, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 0, 0, 32767, 0));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 0, 0, 32768, 0));
    wait_idle();
  endtask

  // Zero sites rejects everything; oversized count acts as full lattice
  task automatic test_site_count_limits();
    set_config(11'd0, PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
    send_site_req(mk_req(elmc_pkg::OP_READ, 0, 0, 0, 0, 0));
    wait_idle();
    set_config(11'd2047, PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
    send_site_req(mk_req(elmc_pkg::OP_LOAD, 1023, 0, 0, 0, 1));
    send_site_req(mk_req(elmc_pkg::OP_UPDATE, 1023, 1023, 65535, 65535, 0));
    send_site_req(mk_req(elmc_pkg::OP_ACCUM, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  function automatic logic [CFG_DW-1:0] pick_prob();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return PROB_ONE;
      default: return CFG_DW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic int unsigned pick_site(input int unsigned n);
    if (n == 0 || $urandom_range(0, 99) < 8) return $urandom_range(0, MAX_SITES - 1);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  // Mostly in-range updates with some loads, reads, sweeps and noise
  function automatic site_req_t random_req();
    int unsigned roll;
    int unsigned n;
    logic [OPCODE_W-1:0] op;
    roll = $urandom_range(0, 99);
    n = active_sites();
    if (roll < 70)      op = elmc_pkg::OP_UPDATE;
    else if (roll < 78) op = elmc_pkg::OP_LOAD;
    else if (roll < 86) op = elmc_pkg::OP_READ;
    else if (roll < 92) op = elmc_pkg::OP_ACCUM;
    else if (roll < 94) op = elmc_pkg::OP_CLEAR;
    else if (roll < 97) op = OP_UNUSED_FIRST + OPCODE_W'($urandom_range(0, 2));
    else                op = elmc_pkg::OP_UPDATE;
    return mk_req(op, pick_site(n), pick_site(n), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 1));
  endfunction

  // Several configurations, one random burst each
  task automatic test_random_traffic();
    logic [10:0] n_list [NUM_PHASES];
    n_list = '{11'd16, 11'd1, 11'd1024, 11'd8, 11'd2, 11'd64, 11'd2047, 11'd3};
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(n_list[p], pick_prob(), pick_prob(), pick_prob(), pick_prob());
      idle_en = (p != 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 0 && k == 40) wait_idle();
        send_site_req(random_req());
      end
      wait_idle();
    end
    idle_en = 1'b1;
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (site_reply_q.size() == 0) begin
        note_error("result with no request outstanding");
      end else begin
        got_want = site_reply_q.pop_front();
        n_checked++;
        if (occupied_o !== got_want.occupied || site_count_o !== got_want.count ||
            status_o !== got_want.status)
          note_error($sformatf("op %0d: occupied %0b/%0b count %0d/%0d status %0b/%0b",
                               got_want.opcode, got_want.occupied, occupied_o,
                               got_want.count, site_count_o, got_want.status,
                               status_o));
      end
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no progress for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < MAX_SITES; k++) begin
      lat_bits[k] = 1'b0;
      occ_cnt[k]  = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_boundary_edges();
    test_bulk_kinetics();
    test_single_site();
    test_site_count_limits();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (site_reply_q.size() != 0) note_error("results missing at end of run");
    $display("Covered %0d requests (%0d updates, %0d sweeps, %0d rejected) over %0d settings",
             n_sent, n_update, n_accum, n_reject, NUM_PHASES + 6);
    $display("Checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
